/* hdl/assert_macros.svh */
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("%m: check failed");
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("%m: check failed");
`endif

/* hdl/sapf_pkg.sv */
// ----------------------------------------------------------------------------
// sapf_pkg
// Types, constants and size decode for the sprite pixel fetch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sapf_pkg;
	localparam int TILE_MEM_BYTES = 32768;
	localparam int PALETTE_ENTRIES = 256;
	localparam int TILE_AW = $clog2(TILE_MEM_BYTES);
	localparam int PAL_AW = $clog2(PALETTE_ENTRIES);
	localparam logic [1:0] MODE_TILE = 2'd0;
	localparam logic [1:0] MODE_PAL = 2'd1;
	localparam logic [1:0] MODE_RENDER = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam logic [1:0] OBJ_MODE_OFF = 2'd3;
	localparam logic [1:0] VIS_OFF = 2'd0;
	localparam logic [1:0] VIS_ON = 2'd1;
	localparam logic [1:0] VIS_OUT = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [14:0] mem_addr;
		logic [31:0] mem_data;
		logic [15:0] attr_zero;
		logic [15:0] attr_one;
		logic [15:0] attr_two;
		logic signed [15:0] param_a;
		logic signed [15:0] param_b;
		logic signed [15:0] param_c;
		logic signed [15:0] param_d;
		logic [6:0] pixel_x;
		logic [6:0] pixel_y;
	} req_t;

	typedef struct packed {
		logic [31:0] pixel_colour;
		logic opaque;
		logic [7:0] box_width;
		logic [7:0] box_height;
		logic [1:0] visibility;
		logic [1:0] draw_priority;
		logic [16:0] first_tile_addr;
		logic outside_box;
	} rsp_t;

	// texel fetch and memory write request from address stage to memory stage
	typedef struct packed {
		logic valid;
		logic tile_we;
		logic pal_we;
		logic [TILE_AW-1:0] waddr;
		logic [31:0] wdata;
		logic [TILE_AW-1:0] taddr;
		logic hi_nib;
		logic bpp8;
		logic [3:0] bank;
		logic fetch;
	} fetch_t;

	// log2 of width / height, 3..6
	function automatic logic [2:0] size_w(input logic [1:0] sz, input logic [1:0] sh);
		logic [2:0] r;
		case (sh)
			2'd1: r = (sz == 2'd0) ? 3'd4 : ((sz == 2'd1) ? 3'd5 : (3'(sz) + 3'd3));
			2'd2: r = (sz == 2'd3) ? 3'd5 : ((sz == 2'd2) ? 3'd4 : 3'd3);
			default: r = 3'(sz) + 3'd3;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] size_h(input logic [1:0] sz, input logic [1:0] sh);
		logic [2:0] r;
		case (sh)
			2'd1: r = (sz == 2'd3) ? 3'd5 : ((sz == 2'd2) ? 3'd4 : 3'd3);
			2'd2: r = (sz == 2'd0) ? 3'd4 : ((sz == 2'd1) ? 3'd5 : (3'(sz) + 3'd3));
			default: r = 3'(sz) + 3'd3;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

/* hdl/sprite_attribute_pixel_fetch.sv */
// ----------------------------------------------------------------------------
// sprite_attribute_pixel_fetch
// Sprite pixel fetch with object tile memory and palette.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// in       in   in_valid/ready     sapf_pkg::req_t
// out      out  out_valid/ready    sapf_pkg::rsp_t
// cfg      in   cfg_valid/ready    linear_tile_mapping
// One request at a time: decode/multiply, tile read, palette read.
// The request passes the stage-1 registers, the tile read and the palette read, then
// the result is registered; the next request is taken only once the last is done.
// A result that arrives while out_data waits on out_ready goes to a holding register;
// in_ready drops while a request is in flight or that register is full.
// Memory contents are undefined after reset; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sprite_attribute_pixel_fetch (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire sapf_pkg::req_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output sapf_pkg::rsp_t out_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_data
);
	logic busy_q, lin_q, hold_v_q, done, opaque, fetched;
	logic [31:0] colour;
	sapf_pkg::fetch_t fetch;
	sapf_pkg::rsp_t meta, res_d, hold_q;
	logic start, out_free;

	assign in_ready = !busy_q && !hold_v_q;
	assign start = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_free = !out_valid || out_ready;

	// bit 16 of the tile address marks a render
	always_comb begin
		res_d = meta;
		res_d.pixel_colour = colour;
		res_d.opaque = opaque;
		res_d.outside_box = meta.outside_box || (meta.first_tile_addr[16] && !fetched);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			lin_q <= 1'b0;
			out_valid <= 1'b0;
			hold_v_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				lin_q <= cfg_data;
			end
			if (start) begin
				busy_q <= 1'b1;
			end else if (done) begin
				busy_q <= 1'b0;
			end
			if (done && !out_free) begin
				hold_v_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				hold_v_q <= 1'b0;
			end
			if (done) begin
				out_valid <= 1'b1;
			end else if (out_ready && !hold_v_q) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done && out_free) begin
			out_data <= res_d;
		end else if (out_valid && out_ready && hold_v_q) begin
			out_data <= hold_q;
		end
		if (done && !out_free) begin
			hold_q <= res_d;
		end
	end

	sapf_addr u_addr (
		.clk(clk), .arst_n(arst_n), .start(start), .req(in_data),
		.linear_tile_mapping(lin_q), .fetch(fetch), .meta(meta)
	);

	sapf_mem u_mem (
		.clk(clk), .arst_n(arst_n), .fetch(fetch), .done(done),
		.colour(colour), .opaque(opaque), .fetched(fetched)
	);
endmodule
`default_nettype wire

/* hdl/sapf_addr.sv */
// ----------------------------------------------------------------------------
// sapf_addr
// Attribute decode, affine transform and tile address generation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sapf_addr (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire sapf_pkg::req_t req,
	input wire logic linear_tile_mapping,
	output sapf_pkg::fetch_t fetch,
	output sapf_pkg::rsp_t meta
);
	// stage 1: decode and multiply
	logic [2:0] lw, lh;
	logic affine, dbl, bpp8;
	logic [7:0] w8, h8, bw, bh;
	logic [8:0] x2;
	logic [7:0] y2;
	logic [1:0] vis;
	logic signed [8:0] dx, dy;
	logic signed [24:0] m_a_s1, m_b_s1, m_c_s1, m_d_s1;
	logic [6:0] mx_s1, my_s1;
	logic out1_s1, aff_s1, bpp8_s1, v1_s1, ren_s1;
	logic [2:0] lw_s1, lh_s1;
	logic [9:0] tile_s1;
	logic [3:0] bank_s1;
	sapf_pkg::req_t req_s1;
	sapf_pkg::rsp_t meta_d;

	always_comb begin
		affine = req.attr_zero[8];
		dbl = affine & req.attr_zero[9];
		bpp8 = req.attr_zero[13];
		lw = sapf_pkg::size_w(req.attr_one[15:14], req.attr_zero[15:14]);
		lh = sapf_pkg::size_h(req.attr_one[15:14], req.attr_zero[15:14]);
		w8 = 8'd1 << lw;
		h8 = 8'd1 << lh;
		bw = dbl ? (w8 << 1) : w8;
		bh = dbl ? (h8 << 1) : h8;
		x2 = req.attr_one[8:0] + {1'b0, bw} - 9'd1;
		y2 = req.attr_zero[7:0] + bh - 8'd1;
		if ((!affine && req.attr_zero[9]) || req.attr_zero[11:10] == sapf_pkg::OBJ_MODE_OFF) begin
			vis = sapf_pkg::VIS_OFF;
		end else if ((req.attr_one[8:0] < 9'd240 || x2 < 9'd240)
				&& (req.attr_zero[7:0] < 8'd160 || y2 < 8'd160)) begin
			vis = sapf_pkg::VIS_ON;
		end else begin
			vis = sapf_pkg::VIS_OUT;
		end
		dx = $signed({2'b0, req.pixel_x}) - $signed({1'b0, dbl ? w8 : (w8 >> 1)});
		dy = $signed({2'b0, req.pixel_y}) - $signed({1'b0, dbl ? h8 : (h8 >> 1)});
		meta_d = '0;
		meta_d.box_width = bw;
		meta_d.box_height = bh;
		meta_d.visibility = vis;
		meta_d.draw_priority = req.attr_two[11:10];
		meta_d.first_tile_addr = {2'b10, req.attr_two[9:0], 5'd0};
		meta_d.outside_box = ({1'b0, req.pixel_x} >= bw) || ({1'b0, req.pixel_y} >= bh);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else begin
			v1_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			req_s1 <= req;
			ren_s1 <= req.mode == sapf_pkg::MODE_RENDER;
			m_a_s1 <= dx * req.param_a;
			m_b_s1 <= dy * req.param_b;
			m_c_s1 <= dx * req.param_c;
			m_d_s1 <= dy * req.param_d;
			mx_s1 <= (!affine && req.attr_one[12]) ? 7'(w8 - 8'd1 - {1'b0, req.pixel_x})
				: req.pixel_x;
			my_s1 <= (!affine && req.attr_one[13]) ? 7'(h8 - 8'd1 - {1'b0, req.pixel_y})
				: req.pixel_y;
			out1_s1 <= meta_d.outside_box;
			aff_s1 <= affine;
			bpp8_s1 <= bpp8;
			lw_s1 <= lw;
			lh_s1 <= lh;
			tile_s1 <= req.attr_two[9:0];
			bank_s1 <= bpp8 ? 4'd0 : req.attr_two[15:12];
			if (req.mode == sapf_pkg::MODE_RENDER) begin
				meta <= meta_d;
			end else begin
				meta <= '0;
			end
		end
	end

	// stage 2 (combinational into memory): sum, floor, range, address
	logic signed [25:0] sx, sy;
	logic signed [17:0] xr, yr;
	logic [5:0] ux, uy;
	logic outside;
	logic [7:0] wv, hv;
	logic [9:0] idx, step, tile;
	logic [4:0] lo;
	logic [14:0] taddr;

	always_comb begin
		wv = 8'd1 << lw_s1;
		hv = 8'd1 << lh_s1;
		sx = 26'(m_a_s1) + 26'(m_b_s1);
		sy = 26'(m_c_s1) + 26'(m_d_s1);
		if (aff_s1) begin
			xr = 18'(sx >>> 8) + $signed({10'd0, wv >> 1});
			yr = 18'(sy >>> 8) + $signed({10'd0, hv >> 1});
		end else begin
			xr = $signed({11'd0, mx_s1});
			yr = $signed({11'd0, my_s1});
		end
		outside = out1_s1 || xr < 0 || yr < 0 || xr >= $signed({10'd0, wv})
			|| yr >= $signed({10'd0, hv});
		ux = xr[5:0];
		uy = yr[5:0];
		tile = tile_s1;
		step = bpp8_s1 ? {6'd0, ux[5:3], 1'b0} : {7'd0, ux[5:3]};
		lo = tile[4:0] + step[4:0];
		if (linear_tile_mapping) begin
			idx = tile + 10'(({7'd0, uy[5:3]} << (lw_s1 - 3'd3)) << bpp8_s1) + step;
		end else begin
			idx = {tile[9:5], 5'd0} + {2'd0, uy[5:3], 5'd0} + {5'd0, lo};
		end
		if (bpp8_s1) begin
			taddr = {idx[9:0], 5'd0} + {9'd0, uy[2:0], 3'd0} + {12'd0, ux[2:0]};
		end else begin
			taddr = {idx[9:0], 5'd0} + {10'd0, uy[2:0], 2'd0} + {13'd0, ux[2:1]};
		end
		fetch.valid = v1_s1;
		fetch.tile_we = v1_s1 && req_s1.mode == sapf_pkg::MODE_TILE;
		fetch.pal_we = v1_s1 && req_s1.mode == sapf_pkg::MODE_PAL;
		fetch.waddr = req_s1.mem_addr;
		fetch.wdata = req_s1.mem_data;
		fetch.taddr = taddr;
		fetch.hi_nib = ux[0];
		fetch.bpp8 = bpp8_s1;
		fetch.bank = bank_s1;
		fetch.fetch = ren_s1 && !outside;
	end
endmodule
`default_nettype wire

/* hdl/sapf_mem.sv */
// ----------------------------------------------------------------------------
// sapf_mem
// Tile memory and palette memory, each with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sapf_mem (
	input wire logic clk,
	input wire logic arst_n,
	input wire sapf_pkg::fetch_t fetch,
	output logic done,
	output logic [31:0] colour,
	output logic opaque,
	output logic fetched
);
	logic [7:0] tile_mem [sapf_pkg::TILE_MEM_BYTES];
	logic [31:0] pal_mem [sapf_pkg::PALETTE_ENTRIES];
	logic [7:0] tbyte_s2;
	logic hi_s2, bpp8_s2, fetch_s2, v_s2, v_s3, fetch_s3;
	logic [3:0] bank_s2;
	logic [7:0] cidx;
	logic [31:0] pal_rd_s3;
	logic nz_s3;

	always_ff @(posedge clk) begin
		if (fetch.tile_we) begin
			tile_mem[fetch.waddr] <= fetch.wdata[7:0];
		end
		tbyte_s2 <= tile_mem[fetch.taddr];
		hi_s2 <= fetch.hi_nib;
		bpp8_s2 <= fetch.bpp8;
		bank_s2 <= fetch.bank;
		fetch_s2 <= fetch.fetch;
	end

	always_comb begin
		if (bpp8_s2) begin
			cidx = tbyte_s2;
		end else begin
			cidx = {bank_s2, hi_s2 ? tbyte_s2[7:4] : tbyte_s2[3:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (fetch.pal_we) begin
			pal_mem[fetch.waddr[sapf_pkg::PAL_AW-1:0]] <= fetch.wdata;
		end
		pal_rd_s3 <= pal_mem[cidx];
		nz_s3 <= bpp8_s2 ? (tbyte_s2 != 8'd0)
			: ((hi_s2 ? tbyte_s2[7:4] : tbyte_s2[3:0]) != 4'd0);
		fetch_s3 <= fetch_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= fetch.valid;
			v_s3 <= v_s2;
		end
	end

	assign done = v_s3;
	assign opaque = fetch_s3 && nz_s3;
	assign colour = opaque ? pal_rd_s3 : 32'd0;
	assign fetched = fetch_s3;
endmodule
`default_nettype wire

/* hdl/sapf_checker.sv */
// ----------------------------------------------------------------------------
// sapf_checker
// Port-level checks of the sprite pixel fetch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module sapf_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire sapf_pkg::rsp_t out_data
);
	`CHK_NEXT(a_one_in_flight, clk, arst_n, in_valid && in_ready, !in_ready)
	`CHK_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))
	`CHK_IMPL(a_opaque_colour, clk, arst_n, out_valid && !out_data.opaque,
		out_data.pixel_colour == 32'd0)
	`CHK_IMPL(a_outside_clear, clk, arst_n, out_valid && out_data.outside_box,
		!out_data.opaque)
endmodule

bind sprite_attribute_pixel_fetch sapf_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sprite pixel fetch: loads tile memory and
// palette, renders random sprite pixels under both tile mappings and checks
// every result against an in-bench prediction, with random stalls both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class sprite_pixel_predictor;
	bit [7:0] tile_mem[sapf_pkg::TILE_MEM_BYTES];
	bit tile_set[sapf_pkg::TILE_MEM_BYTES];
	bit [31:0] pal_mem[sapf_pkg::PALETTE_ENTRIES];
	bit pal_set[sapf_pkg::PALETTE_ENTRIES];
	bit linear_map;
	sapf_pkg::rsp_t expected_pixels[$];
	int errors;

	task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	function void sprite_dims(input bit [1:0] sz, input bit [1:0] sh, output int w,
		output int h);
		int big[4];
		int sml[4];
		big = '{16, 32, 32, 64};
		sml = '{8, 8, 16, 32};
		case (sh)
			2'd1: begin w = big[sz]; h = sml[sz]; end
			2'd2: begin w = sml[sz]; h = big[sz]; end
			default: begin w = 8 << sz; h = 8 << sz; end
		endcase
	endfunction

	// ok is cleared when the request would read an entry never written
	function sapf_pkg::rsp_t render(sapf_pkg::req_t r, output bit ok);
		sapf_pkg::rsp_t res;
		bit affine, dbl, hidden, bpp8, hmir, vmir, outside;
		int w, h, bw, bh, xr, yr, dx, dy, cx, cy, x2, y2;
		int unsigned tile, bank, tcol, trow, stp, idx, taddr, cidx, pi;
		res = '0;
		ok = 1;
		if (r.mode != sapf_pkg::MODE_RENDER)
			return res;
		affine = r.attr_zero[8];
		dbl = affine && r.attr_zero[9];
		hidden = !affine && r.attr_zero[9];
		bpp8 = r.attr_zero[13];
		hmir = !affine && r.attr_one[12];
		vmir = !affine && r.attr_one[13];
		tile = r.attr_two[9:0];
		bank = bpp8 ? 0 : r.attr_two[15:12];
		sprite_dims(r.attr_one[15:14], r.attr_zero[15:14], w, h);
		bw = dbl ? w * 2 : w;
		bh = dbl ? h * 2 : h;
		if (hidden || r.attr_zero[11:10] == sapf_pkg::OBJ_MODE_OFF) begin
			res.visibility = sapf_pkg::VIS_OFF;
		end else begin
			x2 = (r.attr_one[8:0] + bw - 1) & 'h1FF;
			y2 = (r.attr_zero[7:0] + bh - 1) & 'hFF;
			res.visibility = ((r.attr_one[8:0] < 240 || x2 < 240) &&
				(r.attr_zero[7:0] < 160 || y2 < 160)) ? sapf_pkg::VIS_ON : sapf_pkg::VIS_OUT;
		end
		outside = 0;
		xr = 0;
		yr = 0;
		if (r.pixel_x >= bw || r.pixel_y >= bh) begin
			outside = 1;
		end else if (affine) begin
			cx = w / 2;
			cy = h / 2;
			dx = int'(r.pixel_x) - (dbl ? cx * 2 : cx);
			dy = int'(r.pixel_y) - (dbl ? cy * 2 : cy);
			xr = ((dx * r.param_a + dy * r.param_b) >>> 8) + cx;
			yr = ((dx * r.param_c + dy * r.param_d) >>> 8) + cy;
		end else begin
			xr = hmir ? w - 1 - r.pixel_x : r.pixel_x;
			yr = vmir ? h - 1 - r.pixel_y : r.pixel_y;
		end
		if (!outside && (xr < 0 || yr < 0 || xr >= w || yr >= h))
			outside = 1;
		if (!outside) begin
			tcol = xr / 8;
			trow = yr / 8;
			stp = bpp8 ? tcol * 2 : tcol;
			if (linear_map)
				idx = tile + trow * ((w / 8) * (bpp8 ? 2 : 1)) + stp;
			else
				idx = (tile & ~32'h1F) + trow * 32 + (((tile & 'h1F) + stp) & 'h1F);
			if (bpp8)
				taddr = (idx * 32 + (yr & 7) * 8 + (xr & 7)) & 'h7FFF;
			else
				taddr = (idx * 32 + (yr & 7) * 4 + ((xr & 7) >> 1)) & 'h7FFF;
			if (!tile_set[taddr])
				ok = 0;
			cidx = tile_mem[taddr];
			if (!bpp8)
				cidx = (xr & 1) ? cidx >> 4 : cidx & 'hF;
			if (cidx != 0) begin
				pi = (bank * 16 + cidx) & 'hFF;
				if (!pal_set[pi])
					ok = 0;
				res.pixel_colour = pal_mem[pi];
				res.opaque = 1;
			end
		end
		res.box_width = 8'(bw);
		res.box_height = 8'(bh);
		res.draw_priority = r.attr_two[11:10];
		res.first_tile_addr = 17'(32'h10000 | ((tile * 32) & 'h7FFF));
		res.outside_box = outside;
		return res;
	endfunction

	function void note_request(sapf_pkg::req_t r);
		bit ok;
		expected_pixels.push_back(render(r, ok));
		if (r.mode == sapf_pkg::MODE_TILE) begin
			tile_mem[r.mem_addr] = r.mem_data[7:0];
			tile_set[r.mem_addr] = 1;
		end else if (r.mode == sapf_pkg::MODE_PAL) begin
			pal_mem[r.mem_addr[7:0]] = r.mem_data;
			pal_set[r.mem_addr[7:0]] = 1;
		end
	endfunction

	task check_pixel(sapf_pkg::rsp_t got);
		sapf_pkg::rsp_t want;
		if (expected_pixels.size() == 0) begin
			report_mismatch("unexpected result", got.pixel_colour, 0);
			return;
		end
		want = expected_pixels.pop_front();
		if (got.pixel_colour !== want.pixel_colour)
			report_mismatch("pixel_colour", got.pixel_colour, want.pixel_colour);
		if (got.opaque !== want.opaque)
			report_mismatch("opaque", got.opaque, want.opaque);
		if (got.box_width !== want.box_width)
			report_mismatch("box_width", got.box_width, want.box_width);
		if (got.box_height !== want.box_height)
			report_mismatch("box_height", got.box_height, want.box_height);
		if (got.visibility !== want.visibility)
			report_mismatch("visibility", got.visibility, want.visibility);
		if (got.draw_priority !== want.draw_priority)
			report_mismatch("draw_priority", got.draw_priority, want.draw_priority);
		if (got.first_tile_addr !== want.first_tile_addr)
			report_mismatch("first_tile_addr", got.first_tile_addr, want.first_tile_addr);
		if (got.outside_box !== want.outside_box)
			report_mismatch("outside_box", got.outside_box, want.outside_box);
	endtask
endclass

module tb_top;
	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	sapf_pkg::req_t in_data = '0;
	logic out_valid;
	logic out_ready = 0;
	sapf_pkg::rsp_t out_data;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_data = 0;

	sprite_pixel_predictor pixels = new();
	bit quiet = 0;
	bit hold_req = 0;
	int hold_left = 0;

	sprite_attribute_pixel_fetch u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		if (out_valid && out_ready)
			pixels.check_pixel(out_data);
		if (hold_req) begin
			hold_left = 400;
			hold_req = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 0;
		end else begin
			out_ready <= quiet || ($urandom_range(0, 99) >= 9);
		end
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic sapf_pkg::req_t rand_req();
		logic [191:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		return bits[$bits(sapf_pkg::req_t)-1:0];
	endfunction

	task automatic send_request(sapf_pkg::req_t r);
		if (!quiet && $urandom_range(0, 99) < 9) begin
			in_valid <= 0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < 30);
		end
		in_valid <= 1;
		in_data <= r;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pixels.note_request(r);
	endtask

	// renders reading unwritten memory are dropped
	task automatic offer(sapf_pkg::req_t r);
		bit ok;
		void'(pixels.render(r, ok));
		if (ok)
			send_request(r);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pixels.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_mapping(bit v);
		drain();
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		pixels.linear_map = v;
	endtask

	function automatic sapf_pkg::req_t write_req(logic [1:0] m, int unsigned a,
		int unsigned d);
		sapf_pkg::req_t r;
		r = rand_req();
		r.mode = m;
		r.mem_addr = 15'(a);
		r.mem_data = d;
		return r;
	endfunction

	function automatic sapf_pkg::req_t render_req(logic [15:0] a0, logic [15:0] a1,
		logic [15:0] a2, int px, int py);
		sapf_pkg::req_t r;
		r = rand_req();
		r.mode = sapf_pkg::MODE_RENDER;
		r.attr_zero = a0;
		r.attr_one = a1;
		r.attr_two = a2;
		r.param_a = 16'sh0100;
		r.param_b = 0;
		r.param_c = 0;
		r.param_d = 16'sh0100;
		r.pixel_x = 7'(px);
		r.pixel_y = 7'(py);
		return r;
	endfunction

	task automatic random_render();
		sapf_pkg::req_t r;
		sapf_pkg::rsp_t box;
		bit ok;
		int tries;
		for (tries = 0; tries < 60; tries++) begin
			r = rand_req();
			r.mode = sapf_pkg::MODE_RENDER;
			if ($urandom_range(0, 3) != 0)
				r.attr_one[15:14] = 2'($urandom_range(0, 1));
			if ($urandom_range(0, 4) != 0)
				r.attr_two[9:0] = 10'($urandom_range(0, 127));
			if ($urandom_range(0, 1)) begin
				r.param_a = 16'sh0100 + $signed(16'($urandom_range(0, 128))) - 16'sh40;
				r.param_b = $signed(16'($urandom_range(0, 128))) - 16'sh40;
				r.param_c = $signed(16'($urandom_range(0, 128))) - 16'sh40;
				r.param_d = 16'sh0100 + $signed(16'($urandom_range(0, 128))) - 16'sh40;
			end
			box = pixels.render(r, ok);
			if ($urandom_range(0, 4) != 0) begin
				r.pixel_x = 7'(r.pixel_x % box.box_width);
				r.pixel_y = 7'(r.pixel_y % box.box_height);
			end
			void'(pixels.render(r, ok));
			if (ok) begin
				send_request(r);
				return;
			end
		end
		send_request(write_req(sapf_pkg::MODE_TILE, $urandom_range(0, 4095), $urandom));
	endtask

	task automatic random_phase(int n);
		int i, k, t;
		for (i = 0; i < n; i++) begin
			quiet = (i >= 60 && i < 160);
			if (i == 200)
				hold_req = 1;
			k = $urandom_range(0, 99);
			if (k < 3) begin
				t = $urandom_range(0, 127);
				for (int b = 0; b < 32; b++)
					send_request(write_req(sapf_pkg::MODE_TILE, t * 32 + b, $urandom));
				i += 31;
			end else if (k < 30) begin
				send_request(write_req(sapf_pkg::MODE_TILE,
					$urandom_range(0, 3) != 0 ? $urandom_range(0, 4095) : $urandom, $urandom));
			end else if (k < 42) begin
				send_request(write_req(sapf_pkg::MODE_PAL, $urandom, $urandom));
			end else if (k < 44) begin
				send_request(write_req(sapf_pkg::MODE_NONE, $urandom, $urandom));
			end else begin
				random_render();
			end
		end
		quiet = 0;
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		set_mapping(0);

		send_request(write_req(sapf_pkg::MODE_TILE, 0, 32'h21));
		send_request(write_req(sapf_pkg::MODE_TILE, 1, 32'hFFFF_FFF0));
		send_request(write_req(sapf_pkg::MODE_TILE, 'h7FFF, 32'hFF));
		send_request(write_req(sapf_pkg::MODE_PAL, 'h7F01, 32'hFFFF_FFFF));
		send_request(write_req(sapf_pkg::MODE_PAL, 2, 32'h0));
		send_request(write_req(sapf_pkg::MODE_PAL, 'h1F, 32'h8001_2345));
		send_request(write_req(sapf_pkg::MODE_PAL, 'h21, 32'h0000_00FF));
		send_request(write_req(sapf_pkg::MODE_PAL, 'hF2, 32'hAAAA_5555));
		send_request(write_req(sapf_pkg::MODE_NONE, 'h7FFF, 32'hFFFF_FFFF));
		offer(render_req(16'h0000, 16'h0000, 16'h0000, 0, 0));
		offer(render_req(16'h0000, 16'h0000, 16'h0000, 1, 0));
		offer(render_req(16'h0000, 16'h0000, 16'hFC00, 2, 0));
		offer(render_req(16'h0000, 16'h1000, 16'h1000, 7, 0));
		offer(render_req(16'h0000, 16'h3000, 16'h0000, 7, 7));
		offer(render_req(16'h2000, 16'h0000, 16'h0000, 0, 0));
		offer(render_req(16'h0300, 16'h0000, 16'h0000, 8, 8));
		offer(render_req(16'h0200, 16'h01FF, 16'h03FF, 0, 0));
		offer(render_req(16'h0CA0, 16'hC0EF, 16'h0000, 127, 127));
		offer(render_req(16'hC3FF, 16'hC1FF, 16'hFFFF, 127, 127));
		offer(render_req(16'h4000, 16'h8000, 16'h0000, 127, 0));
		offer(render_req(16'h8000, 16'h4000, 16'h0000, 0, 127));

		random_phase(360);
		set_mapping(1);
		random_phase(360);
		set_mapping(0);
		random_phase(360);
		set_mapping(1);
		random_phase(360);

		drain();
		repeat (20) @(posedge clk);
		if (pixels.errors == 0 && pixels.expected_pixels.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
